### src/cmsq_pkg.sv
package cmsq_pkg;

  localparam int unsigned CODE_W     = 10;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned POWER_W    = 2 * CODE_W;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned NUM_CHANNELS_DEF = 5;

  // fixed channel roles
  localparam logic [CHAN_W-1:0] CH_CURRENT = 3'd0;
  localparam logic [CHAN_W-1:0] CH_VIN     = 3'd1;
  localparam logic [CHAN_W-1:0] CH_DPLUS   = 3'd3;
  localparam logic [CHAN_W-1:0] CH_DMINUS  = 3'd4;

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_EQUAL_WINDOW = 3'd0,
    REG_BAND_LOW     = 3'd1,
    REG_BAND_HIGH    = 3'd2,
    REG_DCP_FLOOR    = 3'd3,
    REG_HIGH_FLOOR   = 3'd4,
    REG_ZERO_CEILING = 3'd5
  } reg_idx_t;

  localparam logic [CODE_W-1:0] RST_EQUAL_WINDOW = 10'd15;
  localparam logic [CODE_W-1:0] RST_BAND_LOW     = 10'd62;
  localparam logic [CODE_W-1:0] RST_BAND_HIGH    = 10'd155;
  localparam logic [CODE_W-1:0] RST_DCP_FLOOR    = 10'd46;
  localparam logic [CODE_W-1:0] RST_HIGH_FLOOR   = 10'd465;
  localparam logic [CODE_W-1:0] RST_ZERO_CEILING = 10'd15;

  typedef enum logic [CLASS_W-1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_QC2     = 2'd1,
    CLS_DCP     = 2'd2,
    CLS_QC3     = 2'd3
  } charger_class_t;

  typedef struct packed {
    logic [CODE_W-1:0] equal_window;
    logic [CODE_W-1:0] band_low;
    logic [CODE_W-1:0] band_high;
    logic [CODE_W-1:0] dcp_floor;
    logic [CODE_W-1:0] high_floor;
    logic [CODE_W-1:0] zero_ceiling;
  } thresholds_t;

  // codes as they stand after the sample is stored
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [CODE_W-1:0] code;
    logic [CHAN_W-1:0] next_chan;
    logic [CODE_W-1:0] current;
    logic [CODE_W-1:0] vin;
    logic [CODE_W-1:0] dplus;
    logic [CODE_W-1:0] dminus;
  } snapshot_t;

endpackage

### src/cmsq_regs.sv
module cmsq_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmsq_pkg::APB_AW-1:0]   paddr,
  input  logic [cmsq_pkg::APB_DW-1:0]   pwdata,
  output logic [cmsq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output cmsq_pkg::thresholds_t         thr
);

  cmsq_pkg::thresholds_t thr_r;
  logic                  wr_en;
  logic [2:0]            word_idx;
  logic [cmsq_pkg::CODE_W-1:0] wdata;
  logic [cmsq_pkg::CODE_W-1:0] rdata;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign word_idx = paddr[cmsq_pkg::APB_AW-1:2];
  assign wdata    = pwdata[cmsq_pkg::CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.equal_window <= cmsq_pkg::RST_EQUAL_WINDOW;
      thr_r.band_low     <= cmsq_pkg::RST_BAND_LOW;
      thr_r.band_high    <= cmsq_pkg::RST_BAND_HIGH;
      thr_r.dcp_floor    <= cmsq_pkg::RST_DCP_FLOOR;
      thr_r.high_floor   <= cmsq_pkg::RST_HIGH_FLOOR;
      thr_r.zero_ceiling <= cmsq_pkg::RST_ZERO_CEILING;
    end else if (wr_en) begin
      case (word_idx)
        cmsq_pkg::REG_EQUAL_WINDOW: thr_r.equal_window <= wdata;
        cmsq_pkg::REG_BAND_LOW:     thr_r.band_low     <= wdata;
        cmsq_pkg::REG_BAND_HIGH:    thr_r.band_high    <= wdata;
        cmsq_pkg::REG_DCP_FLOOR:    thr_r.dcp_floor    <= wdata;
        cmsq_pkg::REG_HIGH_FLOOR:   thr_r.high_floor   <= wdata;
        cmsq_pkg::REG_ZERO_CEILING: thr_r.zero_ceiling <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (word_idx)
      cmsq_pkg::REG_EQUAL_WINDOW: rdata = thr_r.equal_window;
      cmsq_pkg::REG_BAND_LOW:     rdata = thr_r.band_low;
      cmsq_pkg::REG_BAND_HIGH:    rdata = thr_r.band_high;
      cmsq_pkg::REG_DCP_FLOOR:    rdata = thr_r.dcp_floor;
      cmsq_pkg::REG_HIGH_FLOOR:   rdata = thr_r.high_floor;
      cmsq_pkg::REG_ZERO_CEILING: rdata = thr_r.zero_ceiling;
      default:                    rdata = '0;
    endcase
  end

  assign prdata = {{(cmsq_pkg::APB_DW - cmsq_pkg::CODE_W){1'b0}}, rdata};
  assign thr    = thr_r;

endmodule

### src/cmsq_capture.sv
module cmsq_capture #(
  parameter int unsigned NUM_CHANNELS = cmsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_sample_high,
  input  logic [7:0]              in_sample_low,
  input  logic                    advance,
  output logic                    snap_valid,
  output cmsq_pkg::snapshot_t     snap
);

  localparam logic [cmsq_pkg::CHAN_W-1:0] LAST_CH = cmsq_pkg::CHAN_W'(NUM_CHANNELS - 1);

  logic [cmsq_pkg::CHAN_W-1:0] chan_r, chan_nxt;
  logic [cmsq_pkg::CODE_W-1:0] current_r, vin_r, dplus_r, dminus_r;
  logic [cmsq_pkg::CODE_W-1:0] current_nxt, vin_nxt, dplus_nxt, dminus_nxt;
  logic [cmsq_pkg::CODE_W-1:0] code;
  logic                        valid_r, valid_nxt;
  logic                        in_fire;
  cmsq_pkg::snapshot_t         snap_r;

  assign in_ready = !valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign code     = {in_sample_high, in_sample_low[1:0]};

  always_comb begin
    chan_nxt    = (chan_r >= LAST_CH) ? '0 : chan_r + 1'b1;
    current_nxt = (chan_r == cmsq_pkg::CH_CURRENT) ? code : current_r;
    vin_nxt     = (chan_r == cmsq_pkg::CH_VIN)     ? code : vin_r;
    dplus_nxt   = (chan_r == cmsq_pkg::CH_DPLUS)   ? code : dplus_r;
    dminus_nxt  = (chan_r == cmsq_pkg::CH_DMINUS)  ? code : dminus_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      chan_r    <= '0;
      current_r <= '0;
      vin_r     <= '0;
      dplus_r   <= '0;
      dminus_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (in_fire) begin
        chan_r    <= chan_nxt;
        current_r <= current_nxt;
        vin_r     <= vin_nxt;
        dplus_r   <= dplus_nxt;
        dminus_r  <= dminus_nxt;
      end
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      snap_r.chan      <= chan_r;
      snap_r.code      <= code;
      snap_r.next_chan <= chan_nxt;
      snap_r.current   <= current_nxt;
      snap_r.vin       <= vin_nxt;
      snap_r.dplus     <= dplus_nxt;
      snap_r.dminus    <= dminus_nxt;
    end
  end

  assign snap_valid = valid_r;
  assign snap       = snap_r;

endmodule

### src/cmsq_eval.sv
module cmsq_eval (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             snap_valid,
  input  cmsq_pkg::snapshot_t              snap,
  input  cmsq_pkg::thresholds_t            thr,
  output logic                             advance,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cmsq_pkg::CHAN_W-1:0]      out_sampled_channel,
  output logic [cmsq_pkg::CODE_W-1:0]      out_sample_code,
  output logic [cmsq_pkg::CHAN_W-1:0]      out_next_channel,
  output logic [cmsq_pkg::CLASS_W-1:0]     out_charger_class,
  output logic [cmsq_pkg::POWER_W-1:0]     out_power_product
);

  logic                         valid_r, valid_nxt;
  logic [cmsq_pkg::CHAN_W-1:0]  chan_r, next_r;
  logic [cmsq_pkg::CODE_W-1:0]  code_r;
  cmsq_pkg::charger_class_t     class_r, class_nxt;
  logic [cmsq_pkg::POWER_W-1:0] power_r, power_nxt;
  logic [cmsq_pkg::CODE_W-1:0]  diff;
  logic                         lines_equal, a_band, s_band, a_high, s_high, s_low;

  assign advance = !valid_r || out_ready;

  always_comb begin
    diff        = (snap.dplus >= snap.dminus) ? snap.dplus - snap.dminus
                                              : snap.dminus - snap.dplus;
    lines_equal = diff <= thr.equal_window;
    a_band      = (snap.dplus > thr.band_low) && (snap.dplus <= thr.band_high);
    s_band      = (snap.dminus > thr.band_low) && (snap.dminus <= thr.band_high);
    a_high      = snap.dplus > thr.high_floor;
    s_high      = snap.dminus > thr.high_floor;
    s_low       = (snap.dminus != '0) && (snap.dminus <= thr.zero_ceiling);

    if (lines_equal) begin
      if (a_band) begin
        class_nxt = cmsq_pkg::CLS_QC2;
      end else if (snap.dplus > thr.dcp_floor) begin
        class_nxt = cmsq_pkg::CLS_DCP;
      end else begin
        class_nxt = cmsq_pkg::CLS_UNKNOWN;
      end
    end else if (a_high && (s_band || s_high)) begin
      class_nxt = cmsq_pkg::CLS_QC2;
    end else if (a_band && s_low) begin
      class_nxt = cmsq_pkg::CLS_QC2;
    end else if (a_band && s_high) begin
      class_nxt = cmsq_pkg::CLS_QC3;
    end else begin
      class_nxt = cmsq_pkg::CLS_UNKNOWN;
    end

    power_nxt = snap.vin * snap.current;

    if (advance) begin
      valid_nxt = snap_valid;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap_valid) begin
      chan_r  <= snap.chan;
      code_r  <= snap.code;
      next_r  <= snap.next_chan;
      class_r <= class_nxt;
      power_r <= power_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_sampled_channel = chan_r;
  assign out_sample_code     = code_r;
  assign out_next_channel    = next_r;
  assign out_charger_class   = class_r;
  assign out_power_product   = power_r;

endmodule

### src/usb_charger_monitor_sequencer.sv
// Channel  | Direction | Handshake            | Carries
// ---------+-----------+----------------------+----------------------------------------
// in_      | request   | in_valid / in_ready  | sample_high, sample_low (one conversion)
// out_     | response  | out_valid / out_ready| channel, code, next channel, class, power
// cfg      | APB slave | psel/penable/pready  | six 10-bit thresholds at 4*i
//
// One request is taken per cycle unless a stalled result fills both stages. A request
// accepted at a clock edge goes to the capture register and then to the result register.
// Latency is set by the capture register and the result register; the 10x10
// multiply and the threshold compares sit between them.
// Synchronous active-low reset: channel 0 next, all stored codes zero, thresholds
// at their defaults, both pipeline stages empty.
// A stalled result holds the pipe; in_ready drops only when both stages are full
// and out_ready is low.
module usb_charger_monitor_sequencer #(
  parameter int unsigned NUM_CHANNELS = cmsq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_sample_high,
  input  logic [7:0]                    in_sample_low,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cmsq_pkg::CHAN_W-1:0]   out_sampled_channel,
  output logic [cmsq_pkg::CODE_W-1:0]   out_sample_code,
  output logic [cmsq_pkg::CHAN_W-1:0]   out_next_channel,
  output logic [cmsq_pkg::CLASS_W-1:0]  out_charger_class,
  output logic [cmsq_pkg::POWER_W-1:0]  out_power_product,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmsq_pkg::APB_AW-1:0]   paddr,
  input  logic [cmsq_pkg::APB_DW-1:0]   pwdata,
  output logic [cmsq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  cmsq_pkg::thresholds_t thr;
  cmsq_pkg::snapshot_t   snap;
  logic                  snap_valid;
  logic                  advance;

  // threshold registers
  cmsq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // stage 1: store the code to its channel, step the channel, snapshot the codes
  cmsq_capture #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_high (in_sample_high),
    .in_sample_low  (in_sample_low),
    .advance        (advance),
    .snap_valid     (snap_valid),
    .snap           (snap)
  );

  // stage 2: classify D+/D- and form Vin x I into the result register
  cmsq_eval u_eval (
    .clk                 (clk),
    .rst_n               (rst_n),
    .snap_valid          (snap_valid),
    .snap                (snap),
    .thr                 (thr),
    .advance             (advance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sampled_channel (out_sampled_channel),
    .out_sample_code     (out_sample_code),
    .out_next_channel    (out_next_channel),
    .out_charger_class   (out_charger_class),
    .out_power_product   (out_power_product)
  );

endmodule
